@@ rtl/core/msfp_pkg.sv @@
// ----------------------------------------------------------------------------
// msfp_pkg
// Shared constants for the magnetic stripe frame parser: frame layout,
// segment codes and result kinds.
// ----------------------------------------------------------------------------
package msfp_pkg;

   localparam int ByteWidth   = 8;
   localparam int PosWidth    = 3;
   localparam int KindWidth   = 2;
   localparam int CountWidth  = 16;

   typedef logic [ByteWidth-1:0]  byte_type;
   typedef logic [PosWidth-1:0]   pos_type;
   typedef logic [KindWidth-1:0]  kind_type;
   typedef logic [CountWidth-1:0] count_type;

   localparam byte_type HEADER_BYTE = 8'h4D;
   localparam byte_type SEG_ONE     = 8'h01;
   localparam byte_type SEG_NONE    = 8'h00;

   // frame position: hunting, then index of the next byte expected
   localparam pos_type POS_HUNT    = 3'd0;
   localparam pos_type POS_SEGMENT = 3'd1;
   localparam pos_type POS_OFFSET  = 3'd2;
   localparam pos_type POS_LAST_SUM = 3'd6;
   localparam pos_type POS_CHECK   = 3'd7;

   localparam kind_type KIND_OFFSET     = 2'd0;
   localparam kind_type KIND_NO_SEGMENT = 2'd1;
   localparam kind_type KIND_REJECTED   = 2'd2;

   localparam count_type COUNT_MAX       = 16'hFFFF;
   localparam count_type REARM_RESET_VAL = 16'd10;

endpackage

@@ rtl/core/magnetic_stripe_frame_parser_core.sv @@
// ----------------------------------------------------------------------------
// magnetic_stripe_frame_parser_core
// Hunts for the 0x4D header in the sensor byte stream, collects the seven
// frame bytes, checks the byte sum and reports one result per frame, with a
// saturating stripe counter re-armed after a run of no-segment frames.
// ----------------------------------------------------------------------------
//  channel | ports                     | handshake
//  --------+---------------------------+--------------------------
//  req     | req_rx_byte               | req_valid / req_stall
//  rsp     | rsp_frame_kind, ...       | rsp_valid / rsp_stall
//  csr     | csr_rearm_threshold       | csr_valid / csr_ready
//
//  one byte per cycle while req_stall is low; each byte is handled by the frame logic in the cycle
//  it is taken, and the checksum byte loads the result register, so the
//  result appears in the cycle after the last byte of a frame.
//  req_stall rises only while a result sits in the output register and the
//  receiver stalls it. csr_ready is always high.
//  synchronous active-high reset: hunting, counter armed, counts zero,
//  threshold 10.
// ----------------------------------------------------------------------------
module magnetic_stripe_frame_parser_core
   import msfp_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [ByteWidth-1:0]   req_rx_byte,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [KindWidth-1:0]   rsp_frame_kind,
   output logic signed [ByteWidth-1:0] rsp_lateral_offset,
   output logic [CountWidth-1:0]  rsp_stripe_count,
   output logic                   rsp_checksum_ok,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CountWidth-1:0]  csr_rearm_threshold
);

   pos_type   pos_ff, pos_in;
   byte_type  segment_ff, segment_in;
   byte_type  offset_ff, offset_in;
   byte_type  sum_ff, sum_in;
   logic      armed_ff, armed_in;
   count_type idle_ff, idle_in;
   count_type stripes_ff, stripes_in;
   count_type threshold_ff;

   logic      rsp_valid_ff, rsp_valid_in;
   kind_type  kind_ff, kind_in;
   byte_type  rsp_offset_ff, rsp_offset_in;
   logic      sum_ok_ff, sum_ok_in;

   logic      req_accept;
   logic      sum_ok;
   count_type idle_inc;

   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;
   assign csr_ready  = 1'b1;

   assign sum_ok   = (sum_ff == req_rx_byte);
   assign idle_inc = (idle_ff == COUNT_MAX) ? idle_ff : idle_ff + 16'd1;

   always_comb begin
      pos_in        = pos_ff;
      segment_in    = segment_ff;
      offset_in     = offset_ff;
      sum_in        = sum_ff;
      armed_in      = armed_ff;
      idle_in       = idle_ff;
      stripes_in    = stripes_ff;
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      kind_in       = kind_ff;
      rsp_offset_in = rsp_offset_ff;
      sum_ok_in     = sum_ok_ff;

      if (req_accept) begin
         if (pos_ff == POS_HUNT) begin
            if (req_rx_byte == HEADER_BYTE) begin
               pos_in = POS_SEGMENT;
               sum_in = '0;
            end
         end else if (pos_ff inside {[POS_SEGMENT:POS_LAST_SUM]}) begin
            if (pos_ff == POS_SEGMENT) segment_in = req_rx_byte;
            if (pos_ff == POS_OFFSET)  offset_in  = req_rx_byte;
            sum_in = sum_ff + req_rx_byte;
            pos_in = pos_ff + 3'd1;
         end else begin
            // checksum byte: judge the frame
            pos_in        = POS_HUNT;
            rsp_valid_in  = 1'b1;
            sum_ok_in     = sum_ok;
            rsp_offset_in = '0;
            if (sum_ok && segment_ff == SEG_ONE) begin
               kind_in       = KIND_OFFSET;
               rsp_offset_in = offset_ff;
               if (armed_ff) begin
                  if (stripes_ff != COUNT_MAX) stripes_in = stripes_ff + 16'd1;
                  armed_in = 1'b0;
               end
            end else if (segment_ff == SEG_NONE) begin
               kind_in = KIND_NO_SEGMENT;
               if (!armed_ff) begin
                  if (idle_inc >= threshold_ff) begin
                     idle_in  = '0;
                     armed_in = 1'b1;
                  end else begin
                     idle_in = idle_inc;
                  end
               end
            end else begin
               kind_in = KIND_REJECTED;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= POS_HUNT;
         segment_ff   <= '0;
         offset_ff    <= '0;
         sum_ff       <= '0;
         armed_ff     <= 1'b1;
         idle_ff      <= '0;
         stripes_ff   <= '0;
         threshold_ff <= REARM_RESET_VAL;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         segment_ff   <= segment_in;
         offset_ff    <= offset_in;
         sum_ff       <= sum_in;
         armed_ff     <= armed_in;
         idle_ff      <= idle_in;
         stripes_ff   <= stripes_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) threshold_ff <= csr_rearm_threshold;
      end
   end

   // result payload, no reset needed
   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      rsp_offset_ff <= rsp_offset_in;
      sum_ok_ff     <= sum_ok_in;
   end

   count_type rsp_count_ff;
   always_ff @(posedge clock) begin
      if (req_accept && pos_ff == POS_CHECK) rsp_count_ff <= stripes_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_frame_kind     = kind_ff;
   assign rsp_lateral_offset = rsp_offset_ff;
   assign rsp_stripe_count   = rsp_count_ff;
   assign rsp_checksum_ok    = sum_ok_ff;

   // a checksum byte taken always yields a result in the next cycle
   a_result_after_check: assert property (@(posedge clock) disable iff (reset)
      req_accept && pos_ff == POS_CHECK |=> rsp_valid)
      else $error("no result after checksum byte");

   // an offset frame needs a good checksum
   a_offset_needs_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_kind == KIND_OFFSET |-> rsp_checksum_ok)
      else $error("offset frame with bad checksum");

   // offset is zero for every other frame kind
   a_offset_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_kind != KIND_OFFSET |-> rsp_lateral_offset == '0)
      else $error("nonzero offset on non-offset frame");

   // stripe counter never goes down
   a_count_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> stripes_ff >= $past(stripes_ff))
      else $error("stripe counter decreased");

endmodule

@@ dv/tb_magnetic_stripe_frame_parser_core.sv @@
// ----------------------------------------------------------------------------
// tb_magnetic_stripe_frame_parser_core
// Self-checking bench for the stripe frame parser. Sensor bytes are fed from
// a queue, with directed frames first and then random frames, noise and bad
// checksums under several re-arm thresholds. A byte-level frame decoder
// predicts each frame result, and every response is checked field by field.
// Both sides idle at random, and the receiver holds off once for a long time.
// ----------------------------------------------------------------------------
module tb_magnetic_stripe_frame_parser_core;
   import msfp_pkg::*;

   typedef struct packed {
      kind_type  kind;
      byte_type  offset;
      count_type count;
      logic      sum_ok;
   } frame_result_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_stall;
   logic [ByteWidth-1:0]         req_rx_byte = '0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic [KindWidth-1:0]         rsp_frame_kind;
   logic signed [ByteWidth-1:0]  rsp_lateral_offset;
   logic [CountWidth-1:0]        rsp_stripe_count;
   logic                         rsp_checksum_ok;
   logic                         csr_valid = 1'b0;
   logic                         csr_ready;
   logic [CountWidth-1:0]        csr_rearm_threshold = '0;

   // decoder state, mirrors the block after reset
   pos_type   hunt_pos   = POS_HUNT;
   byte_type  seg_code   = '0;
   byte_type  offset_val = '0;
   byte_type  byte_sum   = '0;
   logic      armed      = 1'b1;
   count_type idle_run   = '0;
   count_type stripes    = '0;
   count_type threshold  = REARM_RESET_VAL;

   byte_type         sensor_q[$];
   frame_result_type frame_q[$];

   int errors     = 0;
   int cycle_n    = 0;
   int rsp_seen   = 0;
   int hold_left  = 0;
   bit hold_done  = 1'b0;
   logic quiet;

   magnetic_stripe_frame_parser_core u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_rx_byte         (req_rx_byte),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_frame_kind      (rsp_frame_kind),
      .rsp_lateral_offset  (rsp_lateral_offset),
      .rsp_stripe_count    (rsp_stripe_count),
      .rsp_checksum_ok     (rsp_checksum_ok),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_rearm_threshold (csr_rearm_threshold)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_n <= cycle_n + 1;
   end

   // no idling on either side inside this window
   assign quiet = (cycle_n >= 850) && (cycle_n < 1250);

   function automatic void decode_byte(input byte_type b);
      frame_result_type r;
      logic good;
      if (hunt_pos == POS_HUNT) begin
         if (b == HEADER_BYTE) begin
            hunt_pos = POS_SEGMENT;
            byte_sum = '0;
         end
      end else if (hunt_pos != POS_CHECK) begin
         if (hunt_pos == POS_SEGMENT)
            seg_code = b;
         else if (hunt_pos == POS_OFFSET)
            offset_val = b;
         byte_sum = byte_sum + b;
         hunt_pos = hunt_pos + 3'd1;
      end else begin
         hunt_pos = POS_HUNT;
         good = (byte_sum == b);
         r.sum_ok = good;
         r.offset = '0;
         if (good && seg_code == SEG_ONE) begin
            r.kind = KIND_OFFSET;
            r.offset = offset_val;
            if (armed) begin
               if (stripes != COUNT_MAX)
                  stripes = stripes + 16'd1;
               armed = 1'b0;
            end
         end else if (seg_code == SEG_NONE) begin
            r.kind = KIND_NO_SEGMENT;
            if (!armed) begin
               if (idle_run != COUNT_MAX)
                  idle_run = idle_run + 16'd1;
               if (idle_run >= threshold) begin
                  idle_run = '0;
                  armed = 1'b1;
               end
            end
         end else begin
            r.kind = KIND_REJECTED;
         end
         r.count = stripes;
         frame_q.push_back(r);
      end
   endfunction

   // header, segment, offset, four filler bytes, checksum (optionally corrupted)
   function automatic void push_frame(input byte_type seg, input byte_type off,
                                      input logic [31:0] fill, input bit bad_sum);
      byte_type sum;
      sum = seg + off + fill[31:24] + fill[23:16] + fill[15:8] + fill[7:0];
      if (bad_sum)
         sum = sum ^ byte_type'($urandom_range(255, 1));
      sensor_q.push_back(HEADER_BYTE);
      sensor_q.push_back(seg);
      sensor_q.push_back(off);
      sensor_q.push_back(fill[31:24]);
      sensor_q.push_back(fill[23:16]);
      sensor_q.push_back(fill[15:8]);
      sensor_q.push_back(fill[7:0]);
      sensor_q.push_back(sum);
   endfunction

   function automatic void push_random_traffic(input int n_bytes);
      int start;
      int pick;
      byte_type seg;
      byte_type noise;
      logic [31:0] fill;
      start = sensor_q.size();
      while (sensor_q.size() - start < n_bytes) begin
         pick = $urandom_range(99);
         if (pick < 8) begin
            noise = byte_type'($urandom_range(255));
            if (noise == HEADER_BYTE)
               noise = ~noise;
            sensor_q.push_back(noise);
         end else begin
            pick = $urandom_range(99);
            if (pick < 45)
               seg = SEG_ONE;
            else if (pick < 85)
               seg = SEG_NONE;
            else
               seg = byte_type'($urandom_range(255));
            fill = $urandom;
            // a header byte buried in the frame body now and then
            if ($urandom_range(9) == 0)
               fill[8*$urandom_range(3) +: 8] = HEADER_BYTE;
            push_frame(seg, byte_type'($urandom_range(255)), fill,
                       $urandom_range(99) < 12);
         end
      end
   endfunction

   // driver: sensor byte channel
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            decode_byte(req_rx_byte);
         if (!req_valid || !req_stall) begin
            if (sensor_q.size() > 0 && (quiet || $urandom_range(99) >= 24)) begin
               req_valid <= 1'b1;
               req_rx_byte <= sensor_q.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: frame result channel
   always @(posedge clock) begin
      frame_result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            rsp_seen = rsp_seen + 1;
            if (frame_q.size() == 0) begin
               errors = errors + 1;
               $display("%0t: result with no frame pending, kind %0d count %0d",
                        $time, rsp_frame_kind, rsp_stripe_count);
            end else begin
               want = frame_q.pop_front();
               if (rsp_frame_kind !== want.kind) begin
                  errors = errors + 1;
                  $display("%0t: frame_kind expected %0d, actual %0d",
                           $time, want.kind, rsp_frame_kind);
               end
               if (rsp_lateral_offset !== want.offset) begin
                  errors = errors + 1;
                  $display("%0t: lateral_offset expected %0d, actual %0d",
                           $time, $signed(want.offset), rsp_lateral_offset);
               end
               if (rsp_stripe_count !== want.count) begin
                  errors = errors + 1;
                  $display("%0t: stripe_count expected %0d, actual %0d",
                           $time, want.count, rsp_stripe_count);
               end
               if (rsp_checksum_ok !== want.sum_ok) begin
                  errors = errors + 1;
                  $display("%0t: checksum_ok expected %0d, actual %0d",
                           $time, want.sum_ok, rsp_checksum_ok);
               end
            end
         end
         // one long hold-off so the result register backs up into the input
         if (hold_left > 0) begin
            hold_left = hold_left - 1;
            rsp_stall <= 1'b1;
         end else if (rsp_seen == 40 && !hold_done) begin
            hold_done = 1'b1;
            hold_left = 300;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !quiet && ($urandom_range(99) < 24);
         end
      end
   end

   task automatic wait_drained();
      do @(negedge clock);
      while (sensor_q.size() != 0 || req_valid || frame_q.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_threshold(input count_type value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_rearm_threshold <= value;
      do @(posedge clock);
      while (!csr_ready);
      threshold = value;
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // noise while hunting, then a valid frame with a header inside the body,
      // a second stripe frame while disarmed and a no-segment frame, bad sum
      sensor_q.push_back(8'h00);
      sensor_q.push_back(8'hFF);
      sensor_q.push_back(8'h4C);
      push_frame(SEG_ONE, 8'h80, {HEADER_BYTE, 8'hFF, 8'h00, 8'h7F}, 1'b0);
      push_frame(SEG_ONE, 8'h7F, 32'hFFFF_FFFF, 1'b0);
      push_frame(SEG_NONE, 8'h55, 32'h0000_0000, 1'b1);
      push_random_traffic(110);
      wait_drained();

      write_threshold(16'd1);
      push_random_traffic(130);
      wait_drained();

      write_threshold(16'd0);
      push_random_traffic(130);
      wait_drained();

      write_threshold(COUNT_MAX);
      push_random_traffic(130);
      wait_drained();

      write_threshold(count_type'($urandom_range(20, 2)));
      push_random_traffic(130);
      wait_drained();

      write_threshold(count_type'($urandom_range(65535, 1)));
      push_random_traffic(110);
      wait_drained();

      write_threshold(REARM_RESET_VAL);
      push_random_traffic(130);
      wait_drained();

      repeat (10) @(posedge clock);
      if (errors == 0 && frame_q.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
